@@ rtl/cpr_pressure_weights_3x3_assert.svh @@
// Assertion helpers for the pressure weight block
`ifndef CPR_PRESSURE_WEIGHTS_3X3_ASSERT_SVH
`define CPR_PRESSURE_WEIGHTS_3X3_ASSERT_SVH

// same-cycle implication
`define CPRW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CPRW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/cprw_pkg.sv @@
`timescale 1ns / 1ps
package cprw_pkg;
  localparam int B         = 3;
  localparam int FRAC_BITS = 30;
  localparam int ENT_W     = 32;
  localparam int COF_W     = 64;
  localparam int DET_W     = 100;

  typedef logic signed [ENT_W-1:0] ent_t;
  typedef logic signed [COF_W-1:0] cof_t;
  typedef logic [1:0]              idx_t;

  // (x + 1) mod 3 for x in 0..2
  function automatic idx_t nxt3(input idx_t x);
    idx_t r;
    r = (x == 2'd2) ? 2'd0 : x + 2'd1;
    return r;
  endfunction

  // flat index of row r, column c
  function automatic logic [3:0] ent_idx(input idx_t r, input idx_t c);
    logic [3:0] r4;
    r4 = {2'b00, r};
    return 4'((r4 << 1) + r4 + {2'b00, c});
  endfunction
endpackage

@@ rtl/cprw_cof.sv @@
`timescale 1ns / 1ps
// Two stages: cofactor products, then cofactor differences of column p.
module cprw_cof (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  cprw_pkg::ent_t    a [9],
  input  cprw_pkg::idx_t    p,
  output logic              out_vld,
  output cprw_pkg::cof_t    cof [3],
  output cprw_pkg::ent_t    diag [3]
);
  import cprw_pkg::*;

  cof_t pa [3];
  cof_t pb [3];
  ent_t dg1 [3];
  logic vld1;
  cof_t pa_next [3];
  cof_t pb_next [3];
  ent_t dg_next [3];

  // pick the entries of the cofactor minors for column p
  always_comb begin
    idx_t r1, r2, c1, c2, ii;
    c1 = nxt3(p);
    c2 = nxt3(c1);
    for (int i = 0; i < B; i++) begin
      ii = idx_t'(i);
      r1 = nxt3(ii);
      r2 = nxt3(r1);
      pa_next[i] = a[ent_idx(r1, c1)] * a[ent_idx(r2, c2)];
      pb_next[i] = a[ent_idx(r1, c2)] * a[ent_idx(r2, c1)];
      dg_next[i] = a[ent_idx(ii, p)];
    end
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    if (rst) vld1 <= 1'b0;
    else if (en) vld1 <= in_vld;
    if (en) begin
      pa  <= pa_next;
      pb  <= pb_next;
      dg1 <= dg_next;
    end
  end

  // stage 2: cofactors, wrapped to 64 bits
  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else if (en) out_vld <= vld1;
    if (en) begin
      for (int i = 0; i < B; i++) begin
        cof[i]  <= pa[i] - pb[i];
        diag[i] <= dg1[i];
      end
    end
  end
endmodule

@@ rtl/cprw_det.sv @@
`timescale 1ns / 1ps
// Two stages: split determinant products and max magnitude, then the sum.
module cprw_det (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  cprw_pkg::cof_t    cof [3],
  input  cprw_pkg::ent_t    diag [3],
  output logic              out_vld,
  output logic [63:0]       mag [3],
  output logic [63:0]       maxm,
  output logic [2:0]        cof_neg,
  output logic              det_zero,
  output logic              det_neg
);
  import cprw_pkg::*;

  logic signed [64:0] plo [3];
  logic signed [63:0] phi [3];
  logic [63:0]        mg [3];
  logic [63:0]        mx;
  logic [2:0]         ng;
  logic               vld3;
  logic signed [64:0] plo_next [3];
  logic signed [63:0] phi_next [3];
  logic [63:0]        mg_next [3];
  logic [63:0]        mx_next;
  logic signed [DET_W-1:0] det_next;

  // partial products of diag * cofactor, low half unsigned
  always_comb begin
    for (int i = 0; i < B; i++) begin
      plo_next[i] = diag[i] * $signed({1'b0, cof[i][31:0]});
      phi_next[i] = diag[i] * $signed(cof[i][63:32]);
      mg_next[i]  = cof[i][63] ? 64'(-cof[i]) : 64'(cof[i]);
    end
    mx_next = (mg_next[0] > mg_next[1]) ? mg_next[0] : mg_next[1];
    if (mg_next[2] > mx_next) mx_next = mg_next[2];
  end

  // stage 3
  always_ff @(posedge clk) begin
    if (rst) vld3 <= 1'b0;
    else if (en) vld3 <= in_vld;
    if (en) begin
      plo <= plo_next;
      phi <= phi_next;
      mg  <= mg_next;
      mx  <= mx_next;
      for (int i = 0; i < B; i++) ng[i] <= cof[i][63];
    end
  end

  // determinant sum
  always_comb begin
    det_next = '0;
    for (int i = 0; i < B; i++) begin
      det_next = det_next + $signed({{4{phi[i][63]}}, phi[i], 32'b0})
                          + $signed({{35{plo[i][64]}}, plo[i]});
    end
  end

  // stage 4
  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else if (en) out_vld <= vld3;
    if (en) begin
      mag      <= mg;
      maxm     <= mx;
      cof_neg  <= ng;
      det_zero <= (det_next == '0) || (mx == '0);
      det_neg  <= det_next[DET_W-1];
    end
  end
endmodule

@@ rtl/cprw_div.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per stage, then a rounding stage.
module cprw_div #(
  parameter int TW = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  logic [63:0]   num,
  input  logic [63:0]   den,
  input  logic [TW-1:0] tag_in,
  output logic          out_vld,
  output logic [31:0]   quo,
  output logic [TW-1:0] tag_out
);
  import cprw_pkg::*;

  localparam int N = FRAC_BITS + 1;

  logic [64:0]   rem [N+1];
  logic [63:0]   dv  [N+1];
  logic [31:0]   qq  [N+1];
  logic [TW-1:0] tg  [N+1];
  logic          vl  [N+1];

  assign rem[0] = {1'b0, num};
  assign dv[0]  = den;
  assign qq[0]  = '0;
  assign tg[0]  = tag_in;
  assign vl[0]  = in_vld;

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [64:0] r;
    logic        ge;
    // first stage compares without shifting
    if (k == 0) begin : g_first
      assign r = rem[k];
    end else begin : g_shift
      assign r = {rem[k][63:0], 1'b0};
    end
    assign ge = (r >= {1'b0, dv[k]});

    always_ff @(posedge clk) begin
      if (rst) vl[k+1] <= 1'b0;
      else if (en) vl[k+1] <= vl[k];
      if (en) begin
        rem[k+1] <= ge ? r - {1'b0, dv[k]} : r;
        qq[k+1]  <= {qq[k][30:0], ge};
        dv[k+1]  <= dv[k];
        tg[k+1]  <= tg[k];
      end
    end
  end

  // round to nearest, ties up
  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else if (en) out_vld <= vl[N];
    if (en) begin
      quo     <= qq[N] + {31'b0, ({rem[N][63:0], 1'b0} >= {1'b0, dv[N]})};
      tag_out <= tg[N];
    end
  end
endmodule

@@ rtl/cpr_pressure_weights_3x3.sv @@
`timescale 1ns / 1ps
// Stages from input beat to result beat: 2 cofactor, 2 determinant,
//   31 divider bit stages, 1 rounding stage.
// Throughput: one beat per cycle; the whole pipeline halts while a result beat
//   waits at the output and a new beat enters whenever the last stage moves.
// Reset: rst clears all stage valid bits and sets pressure_index to 0.
module cpr_pressure_weights_3x3 (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [287:0] s_tdata,  // a_r0c0, a_r0c1, a_r0c2, a_r1c0 .. a_r2c2
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,  // weight_0, weight_1, weight_2
  output logic         m_tuser,  // singular
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_data
);
  import cprw_pkg::*;

  logic   en;
  idx_t   p;
  ent_t   a [9];
  logic   v2, v4;
  cof_t   cof [3];
  ent_t   diag [3];
  logic [63:0] mag [3];
  logic [63:0] maxm;
  logic [2:0]  cof_neg;
  logic   det_zero, det_neg;
  logic [2:0]  dvld;
  logic [31:0] q [3];
  logic [1:0]  tg [3];

  assign en        = m_tready || !m_tvalid;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  // pressure index, code 3 wraps to 0
  always_ff @(posedge clk) begin
    if (rst) p <= 2'd0;
    else if (cfg_valid) p <= (cfg_data == 2'd3) ? 2'd0 : cfg_data;
  end

  always_comb begin
    for (int i = 0; i < 9; i++) a[i] = s_tdata[i*32 +: 32];
  end

  cprw_cof u_cof (
    .clk, .rst, .en, .in_vld(s_tvalid), .a, .p,
    .out_vld(v2), .cof, .diag
  );

  cprw_det u_det (
    .clk, .rst, .en, .in_vld(v2), .cof, .diag,
    .out_vld(v4), .mag, .maxm, .cof_neg, .det_zero, .det_neg
  );

  // one divider lane per weight; tag carries {negate, singular}
  for (genvar i = 0; i < 3; i++) begin : g_lane
    cprw_div #(.TW(2)) u_div (
      .clk, .rst, .en, .in_vld(v4), .num(mag[i]), .den(maxm),
      .tag_in({cof_neg[i] ^ det_neg, det_zero}),
      .out_vld(dvld[i]), .quo(q[i]), .tag_out(tg[i])
    );
    assign m_tdata[i*32 +: 32] = tg[i][0] ? 32'd0 : (tg[i][1] ? -q[i] : q[i]);
  end

  assign m_tvalid = dvld[0];
  assign m_tuser  = tg[0][0];

`include "cpr_pressure_weights_3x3_assert.svh"

  `CPRW_ASSERT_NOW(a_sing_zero, m_tvalid && m_tuser, m_tdata == 96'd0, "singular with weights")
  `CPRW_ASSERT_NOW(a_unit_max, m_tvalid && !m_tuser,
    m_tdata[31:0] == 32'h4000_0000 || m_tdata[31:0] == 32'hC000_0000 ||
    m_tdata[63:32] == 32'h4000_0000 || m_tdata[63:32] == 32'hC000_0000 ||
    m_tdata[95:64] == 32'h4000_0000 || m_tdata[95:64] == 32'hC000_0000,
    "no unit weight")
  `CPRW_ASSERT_NXT(a_lanes_sync, dvld[0] || dvld[1] || dvld[2],
    dvld[0] == dvld[1] && dvld[1] == dvld[2], "lanes out of step")
endmodule
